/* sv/ik_pkg.sv */
package ik_pkg;

    localparam int XYW  = 18;
    localparam int CW   = 40;
    localparam int ZW   = 28;
    localparam int ANGW = 17;
    localparam int QDEPTH = 4;
    localparam int SQ_STEPS = 32;

    localparam logic [2:0] REG_LINK_A   = 3'd0;
    localparam logic [2:0] REG_LINK_B   = 3'd1;
    localparam logic [2:0] REG_X_OFF    = 3'd2;
    localparam logic [2:0] REG_Y_OFF    = 3'd3;
    localparam logic [2:0] REG_SH_TRIM  = 3'd4;
    localparam logic [2:0] REG_EL_TRIM  = 3'd5;

    localparam logic signed [ZW-1:0] ANG_HALF_TURN = 28'sd11796480;
    localparam logic signed [31:0] ANG_LIMIT = 32'sd46080;

    localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
        28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945,
        28'sd234379, 28'sd117304, 28'sd58666, 28'sd29335,
        28'sd14668, 28'sd7334, 28'sd3667, 28'sd1833,
        28'sd917, 28'sd458, 28'sd229, 28'sd115,
        28'sd57, 28'sd29, 28'sd14, 28'sd7, 28'sd4, 28'sd2, 28'sd1, 28'sd0,
        28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0, 28'sd0
    };

    typedef struct packed {
        logic [14:0]        link_a;
        logic [14:0]        link_b;
        logic signed [15:0] x_off;
        logic signed [15:0] y_off;
        logic signed [15:0] sh_trim;
        logic signed [15:0] el_trim;
    } ik_cfg_t;

    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic                  bad;
    } ik_item_t;

    function automatic logic signed [ANGW-1:0] sat_angle(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = v;
        if (t > ANG_LIMIT)
            t = ANG_LIMIT;
        if (t < -ANG_LIMIT)
            t = -ANG_LIMIT;
        return t[ANGW-1:0];
    endfunction

endpackage

/* sv/ik_queue.sv */
module ik_queue #(
    parameter int W = 37,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         nonempty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

/* sv/ik_front.sv */
module ik_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ik_pkg::ik_cfg_t       cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] target_x,
    input  logic [COORD_BITS-1:0] target_y,
    input  logic                  q_full,
    output logic                  q_push,
    output ik_pkg::ik_item_t      q_item
);
    logic             f_valid_reg;
    ik_pkg::ik_item_t f_item_reg, f_item_next;
    logic signed [33:0] x_wide, y_wide;
    logic             adv;

    assign adv      = !f_valid_reg || !q_full;
    assign in_stall = !adv;
    assign q_push   = f_valid_reg && !q_full;
    assign q_item   = f_item_reg;

    always_comb
    begin
        x_wide = 34'($signed(target_x)) + 34'(cfg.x_off);
        y_wide = 34'($signed(target_y)) + 34'(cfg.y_off);
        f_item_next.x = x_wide[ik_pkg::XYW-1:0];
        f_item_next.y = y_wide[ik_pkg::XYW-1:0];
        f_item_next.bad = (cfg.link_a == '0) || (cfg.link_b == '0) ||
                          (x_wide > 34'sd65534) || (x_wide < -34'sd65534) ||
                          (y_wide > 34'sd65534) || (y_wide < -34'sd65534);
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            f_item_reg <= f_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= in_valid;
    end
endmodule

/* sv/ik_cordic.sv */
module ik_cordic #(
    parameter int STEPS = 16
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [ik_pkg::CW-1:0] in_x,
    input  logic signed [ik_pkg::CW-1:0] in_y,
    output logic signed [ik_pkg::ZW-1:0] z_out
);
    logic signed [ik_pkg::CW-1:0] x_reg [STEPS+1];
    logic signed [ik_pkg::CW-1:0] y_reg [STEPS+1];
    logic signed [ik_pkg::ZW-1:0] z_reg [STEPS+1];

    assign z_out = z_reg[STEPS];

    // pre-rotate the left half plane by a half turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_x < 0)
            begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                z_reg[0] <= (in_y >= 0) ? ik_pkg::ANG_HALF_TURN : -ik_pkg::ANG_HALF_TURN;
            end
            else
            begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ik_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ik_pkg::ATAN_TAB[i];
                end
            end
        end
    end
endmodule

/* sv/ik_back.sv */
module ik_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ik_pkg::ik_cfg_t                cfg,
    input  logic                           q_nonempty,
    input  ik_pkg::ik_item_t               q_item,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [ik_pkg::ANGW-1:0] shoulder_angle,
    output logic signed [ik_pkg::ANGW-1:0] elbow_angle,
    output logic                           unreachable
);
    localparam int NS = ik_pkg::SQ_STEPS;
    localparam int NC = CORDIC_STEPS + 1;
    localparam int NV = 4 + NS + NC + 1;

    typedef struct packed {
        logic signed [ik_pkg::XYW-1:0] x;
        logic signed [ik_pkg::XYW-1:0] y;
        logic signed [35:0]            den;
        logic                          bad;
    } meta_t;

    logic              adv;
    logic [NV-1:0]     v_reg;

    // link geometry, refreshed every cycle from the registers
    logic [31:0]        hi_reg;
    logic [29:0]        lo_reg;
    logic signed [31:0] bbaa_reg;

    ik_pkg::ik_item_t s1_item_reg, s2_item_reg;
    logic [35:0]      sqx_reg, sqy_reg;
    logic [35:0]      r2_reg;
    meta_t            s3_reg, s4_reg;
    logic [31:0]      u_reg, v_reg_d;
    logic [63:0]      d_reg;

    meta_t       sq_meta_reg [NS];
    logic [35:0] sq_rem_reg  [NS];
    logic [31:0] sq_root_reg [NS];
    logic [63:0] sq_d_reg    [NS];

    logic        cb_bad_reg [NC];

    logic signed [ik_pkg::ZW-1:0] z_phi, z_th;
    logic signed [ik_pkg::CW-1:0] phi_x, phi_y, th_x, th_y;

    logic signed [ik_pkg::ANGW-1:0] sh_reg, el_reg;
    logic                           bad_reg;
    logic signed [31:0]             sh_sum, el_sum;

    assign adv   = !v_reg[NV-1] || !out_stall;
    assign q_pop = adv && q_nonempty;

    assign out_valid      = v_reg[NV-1];
    assign shoulder_angle = sh_reg;
    assign elbow_angle    = el_reg;
    assign unreachable    = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NV-2:0], q_nonempty};
    end

    always_ff @(posedge clk)
    begin
        hi_reg   <= 32'(({1'b0, cfg.link_a} + {1'b0, cfg.link_b}) *
                        ({1'b0, cfg.link_a} + {1'b0, cfg.link_b}));
        lo_reg   <= (cfg.link_a > cfg.link_b) ?
                    30'((cfg.link_a - cfg.link_b) * (cfg.link_a - cfg.link_b)) :
                    30'((cfg.link_b - cfg.link_a) * (cfg.link_b - cfg.link_a));
        bbaa_reg <= $signed(32'(cfg.link_b * cfg.link_b)) -
                    $signed(32'(cfg.link_a * cfg.link_a));
    end

    // squares, sum, range check, radicand
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= q_item;
            sqx_reg     <= 36'(q_item.x * q_item.x);
            sqy_reg     <= 36'(q_item.y * q_item.y);

            s2_item_reg <= s1_item_reg;
            r2_reg      <= sqx_reg + sqy_reg;

            s3_reg.x   <= s2_item_reg.x;
            s3_reg.y   <= s2_item_reg.y;
            s3_reg.den <= $signed(r2_reg) + 36'(bbaa_reg);
            s3_reg.bad <= s2_item_reg.bad || (r2_reg == '0) ||
                          (r2_reg > 36'(hi_reg)) || (r2_reg < 36'(lo_reg));
            u_reg      <= 32'(36'(hi_reg) - r2_reg);
            v_reg_d    <= 32'(r2_reg - 36'(lo_reg));

            s4_reg <= s3_reg;
            d_reg  <= u_reg * v_reg_d;
        end
    end

    // restoring square root, two radicand bits a stage
    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        logic [35:0] rem_in, trial, rem_sh;
        logic [31:0] root_in;
        logic [63:0] d_in;
        meta_t       meta_in;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign d_in    = d_reg;
            assign meta_in = s4_reg;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign d_in    = sq_d_reg[k-1];
            assign meta_in = sq_meta_reg[k-1];
        end

        assign rem_sh = {rem_in[33:0], d_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_meta_reg[k] <= meta_in;
                sq_d_reg[k]    <= {d_in[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    sq_rem_reg[k]  <= rem_sh - trial;
                    sq_root_reg[k] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[k]  <= rem_sh;
                    sq_root_reg[k] <= {root_in[30:0], 1'b0};
                end
            end
        end
    end

    assign phi_x = ik_pkg::CW'(sq_meta_reg[NS-1].den);
    assign phi_y = $signed(ik_pkg::CW'(sq_root_reg[NS-1]));
    assign th_x  = ik_pkg::CW'(sq_meta_reg[NS-1].x);
    assign th_y  = ik_pkg::CW'(sq_meta_reg[NS-1].y);

    ik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_phi (
        .clk   (clk),
        .en    (adv),
        .in_x  (phi_x),
        .in_y  (phi_y),
        .z_out (z_phi)
    );

    ik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_th (
        .clk   (clk),
        .en    (adv),
        .in_x  (th_x),
        .in_y  (th_y),
        .z_out (z_th)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cb_bad_reg[0] <= sq_meta_reg[NS-1].bad;
            for (int j = 1; j < NC; j++)
                cb_bad_reg[j] <= cb_bad_reg[j-1];
        end
    end

    // round to 1/64 degree, trim, saturate
    always_comb
    begin
        sh_sum = ((32'(z_th) - 32'(z_phi) + 32'sd512) >>> 10) + 32'(cfg.sh_trim);
        el_sum = ((32'sd512 - 32'(z_phi)) >>> 10) + 32'(cfg.el_trim);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bad_reg <= cb_bad_reg[NC-1];
            sh_reg  <= cb_bad_reg[NC-1] ? '0 : ik_pkg::sat_angle(sh_sum);
            el_reg  <= cb_bad_reg[NC-1] ? '0 : ik_pkg::sat_angle(el_sum);
        end
    end
endmodule

/* sv/two_link_arm_inverse_kinematics.sv */
// Stages from an accepted word to its result word: front 1, queue 1,
// squares/range/radicand 4, square root 32, CORDIC CORDIC_STEPS + 1,
// rounding 1. Throughput: one word per cycle while out_stall is low, set by the
// fully pipelined square root and the two CORDIC pipelines.
// Reset: rst_n clears all valid bits and loads the register reset values.
module two_link_arm_inverse_kinematics #(
    parameter int COORD_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [4:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [COORD_BITS-1:0]          target_x,
    input  logic [COORD_BITS-1:0]          target_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [ik_pkg::ANGW-1:0] shoulder_angle,
    output logic signed [ik_pkg::ANGW-1:0] elbow_angle,
    output logic                           unreachable
);
    ik_pkg::ik_cfg_t  cfg_reg;
    logic [2:0]       idx;
    logic             wr_en;
    logic             q_full, q_push, q_pop, q_nonempty;
    ik_pkg::ik_item_t q_wr_item, q_rd_item;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_a  <= 15'd3840;
            cfg_reg.link_b  <= 15'd3840;
            cfg_reg.x_off   <= 16'sd1664;
            cfg_reg.y_off   <= -16'sd1024;
            cfg_reg.sh_trim <= -16'sd640;
            cfg_reg.el_trim <= -16'sd4928;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ik_pkg::REG_LINK_A:  cfg_reg.link_a  <= pwdata[14:0];
                ik_pkg::REG_LINK_B:  cfg_reg.link_b  <= pwdata[14:0];
                ik_pkg::REG_X_OFF:   cfg_reg.x_off   <= pwdata[15:0];
                ik_pkg::REG_Y_OFF:   cfg_reg.y_off   <= pwdata[15:0];
                ik_pkg::REG_SH_TRIM: cfg_reg.sh_trim <= pwdata[15:0];
                ik_pkg::REG_EL_TRIM: cfg_reg.el_trim <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ik_pkg::REG_LINK_A:  prdata = 32'(cfg_reg.link_a);
            ik_pkg::REG_LINK_B:  prdata = 32'(cfg_reg.link_b);
            ik_pkg::REG_X_OFF:   prdata = 32'(cfg_reg.x_off);
            ik_pkg::REG_Y_OFF:   prdata = 32'(cfg_reg.y_off);
            ik_pkg::REG_SH_TRIM: prdata = 32'(cfg_reg.sh_trim);
            ik_pkg::REG_EL_TRIM: prdata = 32'(cfg_reg.el_trim);
            default:             prdata = '0;
        endcase
    end

    ik_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .target_x (target_x),
        .target_y (target_y),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_wr_item)
    );

    ik_queue #(.W($bits(ik_pkg::ik_item_t)), .DEPTH(ik_pkg::QDEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wdata    (q_wr_item),
        .pop      (q_pop),
        .rdata    (q_rd_item),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    ik_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_nonempty     (q_nonempty),
        .q_item         (q_rd_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .shoulder_angle (shoulder_angle),
        .elbow_angle    (elbow_angle),
        .unreachable    (unreachable)
    );
endmodule

/* tb/two_link_arm_inverse_kinematics_test.sv */
`timescale 1ns / 1ps

module two_link_arm_inverse_kinematics_test;

    typedef struct {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
    } target_t;

    typedef struct {
        logic signed [ik_pkg::ANGW-1:0] shoulder;
        logic signed [ik_pkg::ANGW-1:0] elbow;
        logic                           unreach;
    } joint_angles_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic [15:0] target_x, target_y;
    logic        out_valid, out_stall;
    logic signed [ik_pkg::ANGW-1:0] shoulder_angle, elbow_angle;
    logic        unreachable;

    // predictor copy of the registers
    logic [14:0]        len_a, len_b;
    logic signed [15:0] off_x, off_y, trim_sh, trim_el;

    target_t       pending_targets[$];
    joint_angles_t expected_angles[$];
    int send_idle_pct, recv_stall_pct;
    int mismatches, words_in, words_out, unreach_seen, cycles, hold_left;
    bit hold_req;

    two_link_arm_inverse_kinematics dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .target_x(target_x), .target_y(target_y),
        .out_valid(out_valid), .out_stall(out_stall), .shoulder_angle(shoulder_angle),
        .elbow_angle(elbow_angle), .unreachable(unreachable)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    // atan2 in 1/65536 degree
    function automatic longint vector_angle(input longint yv, input longint xv);
        longint z, dx, dy;
        z = 0;
        if (xv < 0)
        begin
            z = (yv >= 0) ? longint'(ik_pkg::ANG_HALF_TURN) : -longint'(ik_pkg::ANG_HALF_TURN);
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = xv >>> i;
            dy = yv >>> i;
            if (yv > 0)
            begin
                xv = xv + dy;
                yv = yv - dx;
                z = z + longint'(ik_pkg::ATAN_TAB[i]);
            end
            else
            begin
                xv = xv - dy;
                yv = yv + dx;
                z = z - longint'(ik_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic logic signed [ik_pkg::ANGW-1:0] round_trim(input longint z,
                                                                  input longint trim);
        longint v;
        v = ((z + 512) >>> 10) + trim;
        if (v > 46080)
            v = 46080;
        if (v < -46080)
            v = -46080;
        return v[ik_pkg::ANGW-1:0];
    endfunction

    function automatic joint_angles_t solve_joints(input target_t t);
        joint_angles_t res;
        longint x, y, a, b, r2, hi, lo, s, phi, th;
        longint unsigned d;
        bit bad;
        x = longint'(t.tx) + longint'(off_x);
        y = longint'(t.ty) + longint'(off_y);
        a = longint'(len_a);
        b = longint'(len_b);
        res.shoulder = '0;
        res.elbow = '0;
        bad = (a == 0 || b == 0 || x > 65534 || x < -65534 || y > 65534 || y < -65534);
        if (!bad)
        begin
            r2 = x * x + y * y;
            hi = (a + b) * (a + b);
            lo = (a - b) * (a - b);
            if (r2 == 0 || r2 > hi || r2 < lo)
                bad = 1;
            else
            begin
                d = $unsigned(hi - r2) * $unsigned(r2 - lo);
                s = longint'(int_sqrt(d));
                phi = vector_angle(s, r2 + b * b - a * a);
                th = vector_angle(y, x);
                res.shoulder = round_trim(th - phi, longint'(trim_sh));
                res.elbow = round_trim(-phi, longint'(trim_el));
            end
        end
        if (bad)
        begin
            res.shoulder = '0;
            res.elbow = '0;
        end
        res.unreach = bad;
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                begin
                    expected_angles.push_back(solve_joints('{target_x, target_y}));
                    words_in++;
                end
                if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    target_x <= pending_targets[0].tx;
                    target_y <= pending_targets[0].ty;
                    pending_targets.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_left <= 400;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_out++;
                if (expected_angles.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: sh=%0d el=%0d unr=%0b",
                                 shoulder_angle, elbow_angle, unreachable);
                end
                else
                begin
                    if (expected_angles[0].unreach)
                        unreach_seen++;
                    if (shoulder_angle !== expected_angles[0].shoulder ||
                        elbow_angle !== expected_angles[0].elbow ||
                        unreachable !== expected_angles[0].unreach)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp sh=%0d el=%0d unr=%0b got sh=%0d el=%0d unr=%0b",
                                     expected_angles[0].shoulder, expected_angles[0].elbow,
                                     expected_angles[0].unreach, shoulder_angle, elbow_angle,
                                     unreachable);
                    end
                    expected_angles.pop_front();
                end
            end
            if (hold_left > 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("two_link_arm_inverse_kinematics_test: done, errors");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ik_pkg::REG_LINK_A:  len_a = value[14:0];
            ik_pkg::REG_LINK_B:  len_b = value[14:0];
            ik_pkg::REG_X_OFF:   off_x = value[15:0];
            ik_pkg::REG_Y_OFF:   off_y = value[15:0];
            ik_pkg::REG_SH_TRIM: trim_sh = value[15:0];
            ik_pkg::REG_EL_TRIM: trim_el = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_setup(input int a, b, xo, yo, st, et);
        reg_write(ik_pkg::REG_LINK_A, a);
        reg_write(ik_pkg::REG_LINK_B, b);
        reg_write(ik_pkg::REG_X_OFF, xo);
        reg_write(ik_pkg::REG_Y_OFF, yo);
        reg_write(ik_pkg::REG_SH_TRIM, st);
        reg_write(ik_pkg::REG_EL_TRIM, et);
    endtask

    task automatic add_target(input int x, input int y);
        target_t t;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        t.tx = 16'(x);
        t.ty = 16'(y);
        pending_targets.push_back(t);
    endtask

    task automatic drain();
        while (pending_targets.size() > 0 || in_valid || expected_angles.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    int setups[6][6] = '{
        '{3840, 3840, 1664, -1024, -640, -4928},
        '{32767, 32767, 32767, -32768, 23040, -23040},
        '{3840, 1000, 0, 0, -23040, 23040},
        '{1, 2, 0, 0, 0, 0},
        '{0, 3840, -1664, 1024, 100, -100},
        '{5000, 2500, -1664, 1024, 23040, 23040}
    };

    initial
    begin
        int reach, xo, yo, rx, ry;
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; target_x = '0; target_y = '0; out_stall = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0; hold_left = 0;
        mismatches = 0; words_in = 0; words_out = 0; unreach_seen = 0; cycles = 0;
        len_a = 3840; len_b = 3840; off_x = 1664; off_y = -1024;
        trim_sh = -640; trim_el = -4928;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, origin hit, stretched and out of reach
        add_target(32767, 32767);
        add_target(-32768, -32768);
        add_target(32767, -32768);
        add_target(-32768, 32767);
        add_target(0, 0);
        add_target(-1664, 1024);                // lands on the mount origin
        add_target(7680 - 1664, 1024);          // arm fully stretched
        add_target(-1664, 7680 + 1024);
        add_target(7681 - 1664, 1024);          // just past reach
        add_target(-7680 - 1664, 1024);
        add_target(1000, 2000);
        add_target(-3000, -500);
        add_target(16'h5555, 16'hAAAA - 65536);
        drain();
        write_setup(3840, 1000, 0, 0, 23040, 23040);
        add_target(2840, 0);                    // folded arm
        add_target(4840, 0);                    // stretched
        add_target(2839, 0);                    // inside inner radius
        add_target(0, -2840);
        add_target(0, 4000);                    // straight up, with both trims at +23040
        drain();
        write_setup(3840, 3840, 32767, 32767, -23040, -23040);
        add_target(32767, 32767);
        add_target(-32767, -32767);
        add_target(-32767 - 7000, -32767);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_setup(setups[p][0], setups[p][1], setups[p][2], setups[p][3],
                        setups[p][4], setups[p][5]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (p == 0)
            begin
                @(negedge clk);
                hold_req = 1;
            end
            reach = setups[p][0] + setups[p][1];
            xo = setups[p][2];
            yo = setups[p][3];
            for (int i = 0; i < 90; i++)
            begin
                if ($urandom_range(99) < 70)
                begin
                    // aim inside the workspace square around the mount
                    rx = $urandom_range(2 * reach) - reach;
                    ry = $urandom_range(2 * reach) - reach;
                    add_target(rx - xo, ry - yo);
                end
                else
                    add_target($urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
            end
            drain();
        end

        $display("%0d targets in, %0d angle words out, %0d unreachable, over 6 link setups",
                 words_in, words_out, unreach_seen);
        $display("idle/stall mixes plus a long output hold-off were exercised");
        if (mismatches == 0)
            $display("two_link_arm_inverse_kinematics_test: done, clean");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("two_link_arm_inverse_kinematics_test: done, errors");
        end
        $finish;
    end

endmodule
